/* rtl/core/prc_bvi_pkg.sv */
`timescale 1ns / 1ps

package prc_bvi_pkg;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 5;

    localparam logic [COUNT_W-1:0] MAX_FIELD_BITS = COUNT_W'(32);

    typedef enum logic [OP_W-1:0] {
        OP_BIT    = 3'd0,
        OP_FIELD  = 3'd1,
        OP_BYTE   = 3'd2,
        OP_UVAR   = 3'd3,
        OP_SVAR   = 3'd4,
        OP_FLUSH  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        CMD_BIT   = 2'd0,
        CMD_END   = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        logic      bit_val;
    } t_cmd;

endpackage

/* rtl/core/prc_bit_packer_varint_core.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    i_operation, i_value, i_bit_count
// out      output     o_out_valid / i_out_stall  o_out_byte, o_last
//
// Bits are generated one per cycle while the packer accepts them; an item codes
// 0 bits (ignored item) to 37 bits (four-byte varint), then an end command.
// The next item is taken once the previous end or flush command has passed.
// Each completed byte is held in a pending register so the final byte can carry o_last.
// Synchronous active-low reset clears the open byte and bit position.
// Output stall blocks a second full byte, an end with a byte held, and any flush.

module prc_bit_packer_varint_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [prc_bvi_pkg::OP_W-1:0]      i_operation,
    input  logic [prc_bvi_pkg::VALUE_W-1:0]   i_value,
    input  logic [prc_bvi_pkg::COUNT_W-1:0]   i_bit_count,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [prc_bvi_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                              o_last
);

    logic              cmd_valid;
    logic              cmd_ready;
    prc_bvi_pkg::t_cmd cmd;

    prc_bvi_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_bit_count (i_bit_count),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    prc_bvi_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

/* rtl/core/prc_bvi_seq.sv */
`timescale 1ns / 1ps

module prc_bvi_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [prc_bvi_pkg::OP_W-1:0]      i_operation,
    input  logic [prc_bvi_pkg::VALUE_W-1:0]   i_value,
    input  logic [prc_bvi_pkg::COUNT_W-1:0]   i_bit_count,
    output logic                              o_cmd_valid,
    output prc_bvi_pkg::t_cmd                 o_cmd,
    input  logic                              i_cmd_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BITS,
        S_VHEAD,
        S_VBYTE,
        S_FLUSH,
        S_END
    } t_state;

    t_state                              r_state;
    logic [prc_bvi_pkg::VALUE_W-1:0]     r_val;
    logic [prc_bvi_pkg::IDX_W-1:0]       r_k;
    logic                                r_sgn;
    logic                                r_prev7;

    logic in_fire;
    logic cmd_fire;
    logic v_done;
    logic field_ok;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_fire    = i_in_valid && (r_state == S_IDLE);
    assign cmd_fire   = o_cmd_valid && i_cmd_ready;
    assign field_ok   = (i_bit_count != '0) && (i_bit_count <= prc_bvi_pkg::MAX_FIELD_BITS);

    always_comb begin
        if (r_sgn) begin
            v_done = ((r_val == '0) && !r_prev7) || ((&r_val) && r_prev7);
        end else begin
            v_done = (r_val == '0);
        end
    end

    always_comb begin
        o_cmd_valid     = 1'b1;
        o_cmd.kind      = prc_bvi_pkg::CMD_BIT;
        o_cmd.bit_val   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_valid = 1'b0;
            end
            S_BITS, S_VBYTE: begin
                o_cmd.bit_val = r_val[r_k];
            end
            S_VHEAD: begin
                o_cmd.bit_val = !v_done;
            end
            S_FLUSH: begin
                o_cmd.kind = prc_bvi_pkg::CMD_FLUSH;
            end
            S_END: begin
                o_cmd.kind = prc_bvi_pkg::CMD_END;
            end
            default: begin
                o_cmd_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_val   <= '0;
            r_k     <= '0;
            r_sgn   <= 1'b0;
            r_prev7 <= 1'b0;
        end else begin
            if (in_fire) begin
                r_val   <= i_value;
                r_sgn   <= (i_operation == prc_bvi_pkg::OP_SVAR);
                r_prev7 <= 1'b0;
                unique case (i_operation)
                    prc_bvi_pkg::OP_BIT: begin
                        r_val   <= {{(prc_bvi_pkg::VALUE_W-1){1'b0}}, |i_value};
                        r_k     <= '0;
                        r_state <= S_BITS;
                    end
                    prc_bvi_pkg::OP_FIELD: begin
                        r_k     <= prc_bvi_pkg::IDX_W'(i_bit_count - 6'd1);
                        r_state <= field_ok ? S_BITS : S_END;
                    end
                    prc_bvi_pkg::OP_BYTE: begin
                        r_k     <= prc_bvi_pkg::IDX_W'(7);
                        r_state <= S_BITS;
                    end
                    prc_bvi_pkg::OP_UVAR, prc_bvi_pkg::OP_SVAR: begin
                        r_state <= S_VHEAD;
                    end
                    prc_bvi_pkg::OP_FLUSH: begin
                        r_state <= S_FLUSH;
                    end
                    default: begin
                        r_state <= S_END;
                    end
                endcase
            end else if (cmd_fire) begin
                unique case (r_state)
                    S_BITS: begin
                        if (r_k == '0) begin
                            r_state <= S_END;
                        end else begin
                            r_k <= r_k - 1'b1;
                        end
                    end
                    S_VHEAD: begin
                        r_k     <= prc_bvi_pkg::IDX_W'(7);
                        r_state <= v_done ? S_END : S_VBYTE;
                    end
                    S_VBYTE: begin
                        if (r_k == '0) begin
                            r_val   <= {{8{r_sgn & r_val[prc_bvi_pkg::VALUE_W-1]}},
                                        r_val[prc_bvi_pkg::VALUE_W-1:8]};
                            r_prev7 <= r_val[7];
                            r_state <= S_VHEAD;
                        end else begin
                            r_k <= r_k - 1'b1;
                        end
                    end
                    S_FLUSH, S_END: begin
                        r_state <= S_IDLE;
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/core/prc_bvi_pack.sv */
`timescale 1ns / 1ps

module prc_bvi_pack (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  prc_bvi_pkg::t_cmd                 i_cmd,
    output logic                              o_cmd_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [prc_bvi_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                              o_last
);

    logic [prc_bvi_pkg::BYTE_W-1:0] r_part, n_part;
    logic [2:0]                     r_pos, n_pos;
    logic                           r_pend_v, n_pend_v;
    logic [prc_bvi_pkg::BYTE_W-1:0] r_pend, n_pend;
    logic                           r_ov, n_ov;
    logic [prc_bvi_pkg::BYTE_W-1:0] r_ob, n_ob;
    logic                           r_ol, n_ol;

    logic                           out_free;
    logic                           completes;
    logic                           fire;
    logic [prc_bvi_pkg::BYTE_W-1:0] np;

    assign out_free  = !r_ov || !i_out_stall;
    assign completes = (r_pos == 3'd7);
    assign np        = r_part | ({7'b0, i_cmd.bit_val} << (3'd7 - r_pos));
    assign fire      = i_cmd_valid && o_cmd_ready;

    always_comb begin
        unique case (i_cmd.kind)
            prc_bvi_pkg::CMD_BIT:   o_cmd_ready = !(completes && r_pend_v && !out_free);
            prc_bvi_pkg::CMD_END:   o_cmd_ready = !r_pend_v || out_free;
            prc_bvi_pkg::CMD_FLUSH: o_cmd_ready = out_free;
            default:                o_cmd_ready = 1'b1;
        endcase
    end

    always_comb begin
        n_part   = r_part;
        n_pos    = r_pos;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_ov     = r_ov && i_out_stall;
        n_ob     = r_ob;
        n_ol     = r_ol;
        if (fire) begin
            unique case (i_cmd.kind)
                prc_bvi_pkg::CMD_BIT: begin
                    if (completes) begin
                        if (r_pend_v) begin
                            n_ov = 1'b1;
                            n_ob = r_pend;
                            n_ol = 1'b0;
                        end
                        n_pend_v = 1'b1;
                        n_pend   = np;
                        n_part   = '0;
                        n_pos    = '0;
                    end else begin
                        n_part = np;
                        n_pos  = r_pos + 3'd1;
                    end
                end
                prc_bvi_pkg::CMD_END: begin
                    if (r_pend_v) begin
                        n_ov     = 1'b1;
                        n_ob     = r_pend;
                        n_ol     = 1'b1;
                        n_pend_v = 1'b0;
                    end
                end
                prc_bvi_pkg::CMD_FLUSH: begin
                    n_ov   = 1'b1;
                    n_ob   = r_part;
                    n_ol   = 1'b1;
                    n_part = '0;
                    n_pos  = '0;
                end
                default: begin
                    n_ov = r_ov && i_out_stall;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part   <= '0;
            r_pos    <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
            r_ol     <= 1'b0;
        end else begin
            r_part   <= n_part;
            r_pos    <= n_pos;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
            r_ol     <= n_ol;
        end
        r_pend <= n_pend;
        r_ob   <= n_ob;
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_last      = r_ol;

    a_flush_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (i_cmd.kind == prc_bvi_pkg::CMD_FLUSH) |=> r_ov && r_ol)
        else $error("flush did not load a final byte");

    a_flush_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && (i_cmd.kind == prc_bvi_pkg::CMD_FLUSH) |-> !r_pend_v)
        else $error("flush with a held byte");

    a_end_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (i_cmd.kind == prc_bvi_pkg::CMD_END) && r_pend_v
        |=> r_ov && r_ol && !r_pend_v)
        else $error("end of transaction lost the held byte");

    a_mid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (i_cmd.kind == prc_bvi_pkg::CMD_BIT) && completes && r_pend_v
        |=> r_ov && !r_ol && r_pend_v)
        else $error("intermediate byte not passed on");

endmodule
